// ===== src/assert_macros.svh =====
// Assertion helpers for the RTL, included by skf_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled during reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check on the block's own clock and reset names.
`define ASSERT_STD(lbl, prop, msg) \
   `ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

// ===== src/skf_pkg.sv =====
package skf_pkg;

   localparam int DATA_W    = 32;
   localparam int GAIN_BITS = 16;
   localparam int GAIN_W    = GAIN_BITS + 1;              // k in 0..2^GAIN_BITS
   localparam int DIV_STEPS = GAIN_W;                     // one quotient bit a step
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int CSR_IDX_W = 3;

   localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_NOISE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEASUREMENT_NOISE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_VARIANCE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_ESTIMATE  = 3'd3;

   // reset values
   localparam logic [DATA_W-1:0] RST_PROCESS_NOISE     = 32'd655;
   localparam logic [DATA_W-1:0] RST_MEASUREMENT_NOISE = 32'd65536;
   localparam logic [DATA_W-1:0] RST_INITIAL_VARIANCE  = 32'd65536;
   localparam logic [DATA_W-1:0] RST_INITIAL_ESTIMATE  = 32'd0;

   // controller -> datapath
   typedef struct packed {
      logic capture;    // latch the incoming sample
      logic predict;    // p+q, p+q+r, seed divider
      logic div_step;   // one quotient bit
      logic multiply;   // register both products
      logic update;     // write state and result word
   } cmd_type;

endpackage

// ===== src/scalar_kalman_filter.sv =====
// A captured sample passes predict, the divide steps and multiply; update sets rsp_valid.
// One sample at a time, taken only in idle; the 17-step restoring divider sets the spacing.
// The result word waits in an output register, stalling only if it is still unread at update.
// Reset (synchronous, active high): registers take their defaults, state reloads from them.
// Any config write to a known index also reloads estimate and variance.
module scalar_kalman_filter (
   input  logic                              clock,
   input  logic                              reset,
   // sample channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [skf_pkg::DATA_W-1:0] req_sample_value,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [skf_pkg::DATA_W-1:0] rsp_filtered_value,
   // register write port
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [skf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [skf_pkg::DATA_W-1:0]        csr_data
);

   skf_pkg::cmd_type cmd;
   logic             csr_we;

   // writes are taken only between words
   assign csr_we = csr_valid && csr_ready;

   // sequencer: accept, predict, 17 divide steps, multiply, update
   skf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   // registers, filter state, divider, multipliers, result word
   skf_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_sample_value   (req_sample_value),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_filtered_value (rsp_filtered_value)
   );

endmodule

// ===== src/skf_ctrl.sv =====
`include "assert_macros.svh"

module skf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              csr_ready,
   output skf_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRED,
      ST_DIV,
      ST_MUL,
      ST_UPD
   } state_type;

   state_type                      state_ff, state_in;
   logic [skf_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_PRED;
            end
         end
         ST_PRED: begin
            cmd.predict = 1'b1;
            cnt_in      = skf_pkg::DIV_CNT_W'(skf_pkg::DIV_STEPS - 1);
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.multiply = 1'b1;
            state_in     = ST_UPD;
         end
         ST_UPD: begin
            if (slot_free) begin
               cmd.update   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ASSERT_STD(a_busy_after_accept, (req_valid && !req_stall) |=> req_stall, "accept not followed by busy")
   `ASSERT_STD(a_no_overwrite, (rsp_valid_ff && rsp_stall) |-> !cmd.update, "pending result overwritten")
   `ASSERT_STD(a_update_shows, cmd.update |=> rsp_valid_ff, "update without result word")
   `ASSERT_STD(a_div_enters_full, (state_ff == ST_PRED) |=> (state_ff == ST_DIV && cnt_ff == skf_pkg::DIV_CNT_W'(skf_pkg::DIV_STEPS - 1)), "divider not seeded")

endmodule

// ===== src/skf_dpath.sv =====
module skf_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  skf_pkg::cmd_type               cmd,
   input  logic signed [skf_pkg::DATA_W-1:0] req_sample_value,
   input  logic                           csr_we,
   input  logic [skf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [skf_pkg::DATA_W-1:0]     csr_data,
   output logic signed [skf_pkg::DATA_W-1:0] rsp_filtered_value
);

   localparam int W  = skf_pkg::DATA_W;
   localparam int GW = skf_pkg::GAIN_W;
   localparam int PXW = GW + 1 + W + 1;      // signed k times 33-bit innovation
   localparam int PPW = GW + W;              // (1-k) times variance

   // configuration
   logic [W-1:0] q_ff, q_in, r_ff, r_in, pinit_ff, pinit_in, xinit_ff, xinit_in;
   logic         reload;
   // filter state
   logic [W-1:0]        var_ff, var_in;
   logic signed [W-1:0] est_ff, est_in;
   // per-word working registers
   logic signed [W-1:0] samp_ff;
   logic [W-1:0]        pp_ff;
   logic [W:0]          den_ff;
   logic                den_zero_ff;
   logic [W+1:0]        rem_ff;
   logic [GW-1:0]       quo_ff;
   logic signed [PXW-1:0] px_ff;
   logic [PPW-1:0]      pv_ff;
   logic signed [W-1:0] out_ff;

   // combinational
   logic [W:0]          pp_sum, den_sum;
   logic [W-1:0]        pp_sat;
   logic [W+2:0]        trial;
   logic                qbit;
   logic [W+1:0]        rem_keep;
   logic [GW-1:0]       k;
   logic signed [W:0]   inn;
   logic signed [GW:0]  k_s;
   logic signed [PXW-1:0] px_rnd;
   logic signed [PXW-GW:0] adj;
   logic signed [W+3:0] xsum;
   logic signed [W-1:0] x_new;
   logic [PPW-1:0]      pv_rnd;

   // config write decode; any known index reloads the state
   always_comb begin
      q_in     = q_ff;
      r_in     = r_ff;
      pinit_in = pinit_ff;
      xinit_in = xinit_ff;
      reload   = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            skf_pkg::CSR_PROCESS_NOISE: begin
               q_in = csr_data; reload = 1'b1;
            end
            skf_pkg::CSR_MEASUREMENT_NOISE: begin
               r_in = csr_data; reload = 1'b1;
            end
            skf_pkg::CSR_INITIAL_VARIANCE: begin
               pinit_in = csr_data; reload = 1'b1;
            end
            skf_pkg::CSR_INITIAL_ESTIMATE: begin
               xinit_in = csr_data; reload = 1'b1;
            end
            default: reload = 1'b0;
         endcase
      end
   end

   // predict: saturating p+q, then exact 33-bit denominator
   assign pp_sum  = {1'b0, var_ff} + {1'b0, q_ff};
   assign pp_sat  = pp_sum[W] ? '1 : pp_sum[W-1:0];
   assign den_sum = {1'b0, pp_sat} + {1'b0, r_ff};

   // restoring divider, fractional form: remainder seeded with pp <= den
   assign trial    = {1'b0, rem_ff} - {2'b00, den_ff};
   assign qbit     = !trial[W+2];
   assign rem_keep = qbit ? trial[W+1:0] : rem_ff;

   assign k   = den_zero_ff ? '0 : quo_ff;
   assign inn = {samp_ff[W-1], samp_ff} - {est_ff[W-1], est_ff};
   assign k_s = {1'b0, k};

   // round half up, floor shift
   assign px_rnd = px_ff + PXW'(32'sd1 <<< (skf_pkg::GAIN_BITS - 1));
   assign adj    = px_rnd[PXW-1:skf_pkg::GAIN_BITS];
   assign xsum   = (W+4)'(est_ff) + (W+4)'(adj);
   // signed clamp to the 32-bit range
   always_comb begin
      if (xsum > (W+4)'($signed({1'b0, {(W-1){1'b1}}}))) begin
         x_new = {1'b0, {(W-1){1'b1}}};
      end else if (xsum < (W+4)'($signed({1'b1, {(W-1){1'b0}}}))) begin
         x_new = {1'b1, {(W-1){1'b0}}};
      end else begin
         x_new = xsum[W-1:0];
      end
   end

   assign pv_rnd = pv_ff + (PPW'(1) << (skf_pkg::GAIN_BITS - 1));

   always_comb begin
      var_in = var_ff;
      est_in = est_ff;
      if (reload) begin
         var_in = pinit_in;
         est_in = xinit_in;
      end else if (cmd.update) begin
         var_in = pv_rnd[skf_pkg::GAIN_BITS +: W];
         est_in = x_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff     <= skf_pkg::RST_PROCESS_NOISE;
         r_ff     <= skf_pkg::RST_MEASUREMENT_NOISE;
         pinit_ff <= skf_pkg::RST_INITIAL_VARIANCE;
         xinit_ff <= skf_pkg::RST_INITIAL_ESTIMATE;
         var_ff   <= skf_pkg::RST_INITIAL_VARIANCE;
         est_ff   <= skf_pkg::RST_INITIAL_ESTIMATE;
      end else begin
         q_ff     <= q_in;
         r_ff     <= r_in;
         pinit_ff <= pinit_in;
         xinit_ff <= xinit_in;
         var_ff   <= var_in;
         est_ff   <= est_in;
      end
   end

   // working registers, no reset
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         samp_ff <= req_sample_value;
      end
      if (cmd.predict) begin
         pp_ff       <= pp_sat;
         den_ff      <= den_sum;
         den_zero_ff <= (den_sum == '0);
         rem_ff      <= {2'b00, pp_sat};
         quo_ff      <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= {rem_keep[W:0], 1'b0};
         quo_ff <= {quo_ff[GW-2:0], qbit};
      end
      if (cmd.multiply) begin
         px_ff <= PXW'(k_s) * PXW'(inn);
         pv_ff <= PPW'(skf_pkg::GAIN_ONE - k) * PPW'(pp_ff);
      end
      if (cmd.update) begin
         out_ff <= x_new;
      end
   end

   assign rsp_filtered_value = out_ff;

endmodule

// ===== sim/testbench.sv =====
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // largest sender gap and receiver stall per word, in cycles
   localparam int IDLE_MAX     = 14;
   // Slowest legal spacing of accepted words: sender gap + filter pass + receiver stall.
   // This limit on quiet cycles lies above that spacing; reaching it means a hang.
   localparam int HANG_LIMIT   = 2000;
   // tail after the last word
   localparam int TAIL_CYCLES  = 48;
   localparam int RANDOM_WORDS = 750;

   localparam logic signed [skf_pkg::DATA_W-1:0] EST_TOP    = 32'sh7FFF_FFFF;
   localparam logic signed [skf_pkg::DATA_W-1:0] EST_BOTTOM = 32'sh8000_0000;
   localparam logic [skf_pkg::DATA_W-1:0]        VAR_FULL   = '1;
   localparam longint ROUND_HALF = longint'(1) << (skf_pkg::GAIN_BITS - 1);
   // first index past the register map; writes from here up are dropped
   localparam logic [skf_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED_FIRST =
      skf_pkg::CSR_INITIAL_ESTIMATE + 1'b1;
   localparam int CSR_INDEX_TOP = (1 << skf_pkg::CSR_IDX_W) - 1;

   logic                               clock;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic signed [skf_pkg::DATA_W-1:0]  req_sample_value = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic signed [skf_pkg::DATA_W-1:0]  rsp_filtered_value;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [skf_pkg::CSR_IDX_W-1:0]      csr_index = '0;
   logic [skf_pkg::DATA_W-1:0]         csr_data = '0;

   // filter model: registers and state
   logic [skf_pkg::DATA_W-1:0]         noise_q;
   logic [skf_pkg::DATA_W-1:0]         noise_r;
   logic [skf_pkg::DATA_W-1:0]         start_variance;
   logic signed [skf_pkg::DATA_W-1:0]  start_estimate;
   logic signed [skf_pkg::DATA_W-1:0]  model_estimate;
   logic [skf_pkg::DATA_W-1:0]         model_variance;

   logic signed [skf_pkg::DATA_W-1:0]  pending_estimates[$];
   int                                 errors = 0;
   int                                 quiet_cycles = 0;
   int                                 stall_left = 0;
   bit                                 steady = 1'b0;   // no gaps or stalls while set

   scalar_kalman_filter dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample_value   (req_sample_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_filtered_value (rsp_filtered_value),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Model
   // ---------------------------------------------------------------------

   function automatic void reload_state();
      model_estimate = start_estimate;
      model_variance = start_variance;
   endfunction

   function automatic void model_defaults();
      noise_q        = skf_pkg::RST_PROCESS_NOISE;
      noise_r        = skf_pkg::RST_MEASUREMENT_NOISE;
      start_variance = skf_pkg::RST_INITIAL_VARIANCE;
      start_estimate = skf_pkg::RST_INITIAL_ESTIMATE;
      reload_state();
   endfunction

   // A write to a mapped index also reinitializes the state; others are dropped.
   function automatic void model_write(input logic [skf_pkg::CSR_IDX_W-1:0] idx,
                                       input logic [skf_pkg::DATA_W-1:0] value);
      case (idx)
         skf_pkg::CSR_PROCESS_NOISE:     noise_q = value;
         skf_pkg::CSR_MEASUREMENT_NOISE: noise_r = value;
         skf_pkg::CSR_INITIAL_VARIANCE:  start_variance = value;
         skf_pkg::CSR_INITIAL_ESTIMATE:  start_estimate = value;
         default:                        return;
      endcase
      reload_state();
   endfunction

   // One measurement: predict, gain, correct. Returns the new estimate.
   function automatic logic signed [skf_pkg::DATA_W-1:0] kalman_update(
      input logic signed [skf_pkg::DATA_W-1:0] sample);
      longint unsigned predicted;
      longint unsigned denom;
      longint unsigned gain;
      longint unsigned scaled;
      longint          innovation;
      longint          next_est;
      predicted = 64'(model_variance) + 64'(noise_q);
      if (predicted > 64'(VAR_FULL))
         predicted = 64'(VAR_FULL);
      denom = predicted + 64'(noise_r);
      gain  = (denom == 0) ? 64'd0 : (predicted << skf_pkg::GAIN_BITS) / denom;
      if (gain > 64'(skf_pkg::GAIN_ONE))
         gain = 64'(skf_pkg::GAIN_ONE);
      innovation = longint'(sample) - longint'(model_estimate);
      // arithmetic shift of a signed value floors toward minus infinity
      next_est = longint'(model_estimate)
               + ((longint'(gain) * innovation + ROUND_HALF) >>> skf_pkg::GAIN_BITS);
      if (next_est > longint'(EST_TOP))
         next_est = longint'(EST_TOP);
      if (next_est < longint'(EST_BOTTOM))
         next_est = longint'(EST_BOTTOM);
      model_estimate = next_est[skf_pkg::DATA_W-1:0];
      scaled = (64'(skf_pkg::GAIN_ONE) - gain) * predicted + 64'(ROUND_HALF);
      model_variance = 32'(scaled >> skf_pkg::GAIN_BITS);
      return model_estimate;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // Valid stays up after acceptance; a zero gap reuses it for the next word,
   // a nonzero gap or finish_words drops it.
   task automatic send_sample(input logic signed [skf_pkg::DATA_W-1:0] value);
      int gap;
      gap = steady ? 0 : $urandom_range(0, IDLE_MAX);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_sample_value <= value;
      do @(posedge clock); while (req_stall);
      pending_estimates.push_back(kalman_update(value));
   endtask

   // Sender pauses until every outstanding word has come back.
   task automatic finish_words();
      req_valid <= 1'b0;
      while (pending_estimates.size() != 0)
         @(posedge clock);
   endtask

   // Only written with the filter idle.
   task automatic write_reg(input logic [skf_pkg::CSR_IDX_W-1:0] idx,
                            input logic [skf_pkg::DATA_W-1:0] value);
      finish_words();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      model_write(idx, value);
      @(posedge clock);
   endtask

   task automatic write_all(input logic [skf_pkg::DATA_W-1:0] q,
                            input logic [skf_pkg::DATA_W-1:0] r,
                            input logic [skf_pkg::DATA_W-1:0] p0,
                            input logic [skf_pkg::DATA_W-1:0] x0);
      write_reg(skf_pkg::CSR_PROCESS_NOISE, q);
      write_reg(skf_pkg::CSR_MEASUREMENT_NOISE, r);
      write_reg(skf_pkg::CSR_INITIAL_VARIANCE, p0);
      write_reg(skf_pkg::CSR_INITIAL_ESTIMATE, x0);
   endtask

   // ---------------------------------------------------------------------
   // Result check and receiver stall
   // ---------------------------------------------------------------------

   always @(posedge clock) begin : result_check
      logic signed [skf_pkg::DATA_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_estimates.size() == 0) begin
            $error("filtered_value: unexpected word, expected none, got %0d",
                   rsp_filtered_value);
            errors++;
         end else begin
            want = pending_estimates.pop_front();
            if (rsp_filtered_value !== want) begin
               $error("filtered_value: expected %0d, got %0d", want, rsp_filtered_value);
               errors++;
            end
         end
         stall_left = steady ? 0 : $urandom_range(0, IDLE_MAX);
      end else if (stall_left > 0) begin
         stall_left--;
      end
      rsp_stall <= (stall_left > 0);
   end

   // hang detector: counts edges where no channel moves a word
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
         $display("scalar_kalman_filter: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset register values, extreme and small measurements.
   task automatic test_reset_values();
      send_sample('0);
      send_sample(EST_TOP);
      send_sample(EST_BOTTOM);
      send_sample(-32'sd1);
      send_sample(32'sd1);
   endtask

   // p+q+r == 0: gain forced to zero, estimate must hold.
   task automatic test_zero_denominator();
      write_all('0, '0, '0, 32'sh0012_3456);
      send_sample(EST_TOP);
      send_sample(EST_BOTTOM);
   endtask

   // r == 0 with q > 0: unit gain, estimate snaps to each measurement.
   task automatic test_unit_gain();
      write_all(32'd1, '0, '0, '0);
      send_sample(EST_BOTTOM);
      send_sample(EST_TOP);
      send_sample('0);
   endtask

   // p+q overflows 32 bits and saturates; everything at full scale.
   task automatic test_variance_saturation();
      write_all(VAR_FULL, VAR_FULL, VAR_FULL, EST_TOP);
      send_sample(EST_BOTTOM);
      send_sample(32'sh0000_8000);
      send_sample(EST_TOP);
   endtask

   // Near-unit gain swinging between rails; rounding must not wrap.
   task automatic test_estimate_rails();
      write_all(VAR_FULL, 32'd1, VAR_FULL, EST_BOTTOM);
      send_sample(EST_TOP);
      send_sample(EST_BOTTOM);
   endtask

   // Unmapped indexes are dropped and must not reload state.
   task automatic test_register_map();
      logic [skf_pkg::CSR_IDX_W-1:0] idx;
      for (int i = CSR_UNMAPPED_FIRST; i <= CSR_INDEX_TOP; i++) begin
         idx = skf_pkg::CSR_IDX_W'(i);
         write_reg(idx, $urandom);
         send_sample($urandom);
      end
      write_all(skf_pkg::RST_PROCESS_NOISE, skf_pkg::RST_MEASUREMENT_NOISE,
                skf_pkg::RST_INITIAL_VARIANCE, skf_pkg::RST_INITIAL_ESTIMATE);
   endtask

   // Random settings per phase, then a run of measurements that mostly
   // track a target with noise, so the variance settles as in real use.
   task automatic test_random_tracking();
      int sent;
      int phase_len;
      logic signed [skf_pkg::DATA_W-1:0] target;
      logic signed [skf_pkg::DATA_W-1:0] noise;
      logic signed [skf_pkg::DATA_W-1:0] sample;
      logic [skf_pkg::CSR_IDX_W-1:0] idx;
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         case ($urandom_range(0, 5))
            0: write_all('0, '0, '0, '0);
            1: write_all(VAR_FULL, VAR_FULL, VAR_FULL,
                         $urandom_range(0, 1) ? EST_TOP : EST_BOTTOM);
            2: write_all(skf_pkg::RST_PROCESS_NOISE, skf_pkg::RST_MEASUREMENT_NOISE,
                         skf_pkg::RST_INITIAL_VARIANCE, $urandom);
            default: write_all($urandom >> $urandom_range(0, 31),
                               $urandom >> $urandom_range(0, 31),
                               $urandom >> $urandom_range(0, 31), $urandom);
         endcase
         // now and then a single register, or a dropped write, between phases
         if ($urandom_range(0, 3) == 0) begin
            idx = skf_pkg::CSR_IDX_W'($urandom_range(0, CSR_INDEX_TOP));
            write_reg(idx, $urandom >> $urandom_range(0, 31));
         end
         steady    = ($urandom_range(0, 3) == 0);
         target    = $urandom;
         phase_len = $urandom_range(20, 60);
         for (int i = 0; i < phase_len; i++) begin
            noise = $signed($urandom) >>> $urandom_range(4, 30);
            case ($urandom_range(0, 9))
               0:       sample = $urandom_range(0, 1) ? EST_TOP : EST_BOTTOM;
               1, 2:    sample = $urandom;
               default: sample = target + noise;
            endcase
            if ($urandom_range(0, 15) == 0)
               target = $urandom;
            send_sample(sample);
         end
         sent += phase_len;
      end
      steady = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      model_defaults();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_zero_denominator();
      test_unit_gain();
      test_variance_saturation();
      test_estimate_rails();
      test_register_map();
      test_random_tracking();

      finish_words();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0 && pending_estimates.size() == 0)
         $display("scalar_kalman_filter: match");
      else
         $display("scalar_kalman_filter: mismatch");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/skf_pkg.sv
src/skf_ctrl.sv
src/skf_dpath.sv
src/scalar_kalman_filter.sv
sim/testbench.sv
